[src/broadcast_slot_multi_reader_unit_macros.svh]
// Assertion macros used by the mailbox top level.
`ifndef BROADCAST_SLOT_MULTI_READER_UNIT_MACROS_SVH
`define BROADCAST_SLOT_MULTI_READER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define BSMR_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property whose consequence must hold in the cycle after the trigger.
`define BSMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BSMR_ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define BSMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/bsmr_pkg.sv]
// Shared constants, codes and types of the broadcast mailbox.
`default_nettype none

package bsmr_pkg;

   localparam int MAX_READERS = 8;
   localparam int ID_WIDTH    = 16;
   localparam int DATA_WIDTH  = 64;
   localparam int TOTAL_WIDTH = 64;

   // field widths fixed by the interface
   localparam int CMD_WIDTH    = 2;
   localparam int RC_WIDTH     = 4;
   localparam int STATUS_WIDTH = 3;
   localparam int PEND_WIDTH   = 4;

   // marked-reader count across the chain
   localparam int CNT_WIDTH = $clog2(MAX_READERS + 1);

   // stream packing
   localparam int REQ_BITS  = CMD_WIDTH + ID_WIDTH + 1 + DATA_WIDTH;
   localparam int REQ_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = STATUS_WIDTH + DATA_WIDTH + PEND_WIDTH + 2 * TOTAL_WIDTH;
   localparam int RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   // commands
   localparam logic [CMD_WIDTH-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_QUERY = 2'd2;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_ALREADY  = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_BUSY     = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_TOO_MANY = 3'd4;

   // carry passed from one reader cell to the next
   typedef struct packed {
      logic                 taken;       // an earlier cell claimed the id
      logic                 hit_marked;  // claiming cell already has its mark
      logic [CNT_WIDTH-1:0] marked;      // marks seen so far in active cells
   } link_type;

   // update strobes broadcast to every cell
   typedef struct packed {
      logic clear_table;
      logic clear_marks;
      logic bind_id;
      logic set_mark;
   } cell_ctl_type;

endpackage

`default_nettype wire

[src/bsmr_cell.sv]
// One reader table cell: bound id and read mark, with search carry.
`default_nettype none

module bsmr_cell
   import bsmr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                active,
   input  wire logic [ID_WIDTH-1:0] reader_id,
   input  wire cell_ctl_type        ctl,
   input  wire link_type            link_i,
   output link_type                 link_o
);

   logic [ID_WIDTH-1:0] tab_ff;
   logic [ID_WIDTH-1:0] tab_in;
   logic                mark_ff;
   logic                mark_in;
   logic                hit;

   // first active cell that holds the id or is free claims the request
   assign hit = active && !link_i.taken &&
                ((tab_ff == reader_id) || (tab_ff == '0));

   always_comb begin
      link_o.taken      = link_i.taken || hit;
      link_o.hit_marked = link_i.hit_marked || (hit && mark_ff);
      link_o.marked     = link_i.marked + CNT_WIDTH'(active && mark_ff);
   end

   // next state
   always_comb begin
      tab_in  = tab_ff;
      mark_in = mark_ff;
      priority if (ctl.clear_table) begin
         tab_in  = '0;
         mark_in = 1'b0;
      end else begin
         if (ctl.bind_id && hit) begin
            tab_in = reader_id;
         end
         if (ctl.clear_marks) begin
            mark_in = 1'b0;
         end else if (ctl.set_mark && hit) begin
            mark_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_ff  <= '0;
         mark_ff <= 1'b0;
      end else begin
         tab_ff  <= tab_in;
         mark_ff <= mark_in;
      end
   end

endmodule

`default_nettype wire

[src/bsmr_chain.sv]
// Row of reader cells; the search carry ripples from cell 0 upward.
`default_nettype none

module bsmr_chain
   import bsmr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [RC_WIDTH-1:0] consumer_count,
   input  wire logic [ID_WIDTH-1:0] reader_id,
   input  wire cell_ctl_type        ctl,
   output link_type                 summary
);

   link_type link [0:MAX_READERS];

   assign link[0] = '0;

   // only the first consumer_count cells take part
   for (genvar g = 0; g < MAX_READERS; g++) begin : g_cell
      logic active;
      assign active = (int'(consumer_count) > g);

      bsmr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .active    (active),
         .reader_id (reader_id),
         .ctl       (ctl),
         .link_i    (link[g]),
         .link_o    (link[g+1])
      );
   end

   assign summary = link[MAX_READERS];

endmodule

`default_nettype wire

[src/broadcast_slot_multi_reader_unit.sv]
// Top level of the one-entry broadcast mailbox with a multi-reader table.
// A request is handled in a capture state, then an execute state in which the reader
// cell chain resolves the id and all state updates and the response beat is registered;
// execute waits while rsp stalls. No new request is accepted until execute ends.
// Reset (synchronous, active high) empties the slot, frees every reader cell, clears
// marks, totals and the consumer count. The stored payload is not cleared.
`default_nettype none
`include "broadcast_slot_multi_reader_unit_macros.svh"

module broadcast_slot_multi_reader_unit
   import bsmr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration: consumer count
   input  wire logic                 csr_wr_en,
   input  wire logic [RC_WIDTH-1:0]  csr_wr_data,
   // request stream
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // command[1:0], reader_id[17:2], keep_entry[18], write_data[82:19], zero pad
   input  wire logic [REQ_WIDTH-1:0] req_tdata,
   // response stream
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // status[2:0], read_data[66:3], pending_count[70:67],
   // delete_total[134:71], write_total[198:135], zero pad
   output logic [RSP_WIDTH-1:0]      rsp_tdata
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                     state_ff, state_in;
   logic [CMD_WIDTH-1:0]     cmd_ff;
   logic [ID_WIDTH-1:0]      id_ff;
   logic                     keep_ff;
   logic [DATA_WIDTH-1:0]    wdata_ff;
   logic [RC_WIDTH-1:0]      rc_ff, rc_in;
   logic                     full_ff, full_in;
   logic [DATA_WIDTH-1:0]    payload_ff;
   logic [TOTAL_WIDTH-1:0]   deleted_ff, deleted_in;
   logic [TOTAL_WIDTH-1:0]   written_ff, written_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]     rsp_data_ff, rsp_data_in;

   logic                     req_fire;
   logic                     exec_fire;
   link_type                 summary;
   cell_ctl_type             ctl;

   logic [STATUS_WIDTH-1:0]  status;
   logic [DATA_WIDTH-1:0]    rdata;
   logic                     do_write;
   logic                     do_delete;
   logic [CNT_WIDTH-1:0]     marked_next;
   logic [PEND_WIDTH-1:0]    pending;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign exec_fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // reader cells
   bsmr_chain u_chain (
      .clock          (clock),
      .reset          (reset),
      .consumer_count (rc_ff),
      .reader_id      (id_ff),
      .ctl            (ctl),
      .summary        (summary)
   );

   // command decode and slot decisions for the held request
   always_comb begin
      status      = ST_OK;
      rdata       = '0;
      do_write    = 1'b0;
      do_delete   = 1'b0;
      ctl         = '0;
      unique case (cmd_ff)
         CMD_WRITE: begin
            if (full_ff) begin
               status = ST_BUSY;
            end else begin
               do_write        = 1'b1;
               ctl.clear_marks = exec_fire;
            end
         end
         CMD_READ: begin
            priority if (!full_ff) begin
               status = ST_EMPTY;
            end else if (rc_ff == '0) begin
               rdata     = payload_ff;
               do_delete = !keep_ff;
            end else if ((id_ff == '0) || !summary.taken) begin
               status = ST_TOO_MANY;
            end else if (summary.hit_marked) begin
               status = ST_ALREADY;
            end else begin
               rdata        = payload_ff;
               ctl.bind_id  = exec_fire;
               ctl.set_mark = exec_fire && !keep_ff;
               do_delete    = !keep_ff &&
                              (int'(summary.marked) + 1 >= int'(rc_ff));
            end
         end
         default: begin
            // query and the unused code leave the state alone
         end
      endcase
      ctl.clear_table = csr_wr_en;
   end

   // slot fill state and totals after this request
   always_comb begin
      full_in    = full_ff;
      deleted_in = deleted_ff;
      written_in = written_ff;
      if (exec_fire && do_write) begin
         full_in    = 1'b1;
         written_in = written_ff + TOTAL_WIDTH'(1);
      end
      if (exec_fire && do_delete) begin
         full_in    = 1'b0;
         deleted_in = deleted_ff + TOTAL_WIDTH'(1);
      end
   end

   always_comb begin
      if (do_write) begin
         marked_next = '0;
      end else begin
         marked_next = summary.marked + CNT_WIDTH'(ctl.set_mark);
      end
      if ((full_ff && !do_delete) || do_write) begin
         pending = PEND_WIDTH'(1 + int'(rc_ff) - int'(marked_next));
      end else begin
         pending = '0;
      end
   end

   // response register and state sequencing
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_WIDTH'({written_in, deleted_in, pending, rdata, status});
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // consumer count saturates at the table size
   always_comb begin
      rc_in = rc_ff;
      if (csr_wr_en) begin
         if (int'(csr_wr_data) > MAX_READERS) begin
            rc_in = RC_WIDTH'(MAX_READERS);
         end else begin
            rc_in = csr_wr_data;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rc_ff        <= '0;
         full_ff      <= 1'b0;
         deleted_ff   <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rc_ff        <= rc_in;
         full_ff      <= full_in;
         deleted_ff   <= deleted_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_tdata[CMD_WIDTH-1:0];
         id_ff    <= req_tdata[CMD_WIDTH +: ID_WIDTH];
         keep_ff  <= req_tdata[CMD_WIDTH + ID_WIDTH];
         wdata_ff <= req_tdata[CMD_WIDTH + ID_WIDTH + 1 +: DATA_WIDTH];
      end
      if (exec_fire && do_write) begin
         payload_ff <= wdata_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `BSMR_ASSERT_NEXT(a_write_fills, clock, reset, exec_fire && do_write,
      full_ff && (written_ff == $past(written_ff) + TOTAL_WIDTH'(1)),
      "accepted write did not fill the slot and count")

   `BSMR_ASSERT_ALWAYS(a_marks_bounded, clock, reset,
      int'(summary.marked) <= int'(rc_ff),
      "marked readers exceed the consumer count")

   `BSMR_ASSERT_NEXT(a_empty_pending, clock, reset, exec_fire && !full_in,
      rsp_data_ff[STATUS_WIDTH + DATA_WIDTH +: PEND_WIDTH] == '0,
      "pending count nonzero for an empty slot")

endmodule

`default_nettype wire
